// File: hw/rtl/fifo_tlb_with_pid_flush_macros.svh
// assertion macros shared by the checker
`ifndef FIFO_TLB_WITH_PID_FLUSH_MACROS_SVH
`define FIFO_TLB_WITH_PID_FLUSH_MACROS_SVH

// same-cycle implication, checked at every rising clk outside reset
`define FTLB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ftlb_pkg.sv
package ftlb_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PID_W       = 16;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int CFG_W       = 5;
    localparam int FUNC_W      = 2;

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam int CNT_W = $clog2(TLB_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam int S_TDATA_W = ((PID_W + PAGE_W + FRAME_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP    = 2'd0,
        FUNC_INSERT    = 2'd1,
        FUNC_FLUSH_ALL = 2'd2,
        FUNC_FLUSH_PID = 2'd3
    } func_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture the incoming transaction
        logic exec;       // first step of the operation
        logic scan_step;  // one entry of the flush-by-pid compaction
        logic pick;       // select oldest matching entry
        logic load_out;   // move result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        func_t func;
        logic  scan_end;
        logic  out_free;
    } status_t;

endpackage

// File: hw/rtl/ftlb_dp.sv
module ftlb_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ftlb_pkg::CFG_W-1:0]         cfg_wdata,
    input  ftlb_pkg::func_t                    in_func,
    input  logic [ftlb_pkg::PID_W-1:0]         in_pid,
    input  logic [ftlb_pkg::PAGE_W-1:0]        in_page,
    input  logic [ftlb_pkg::FRAME_W-1:0]       in_frame,
    input  ftlb_pkg::cmd_t                     cmd,
    output ftlb_pkg::status_t                  status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [ftlb_pkg::FRAME_W-1:0]       out_frame
);

    localparam int N     = ftlb_pkg::TLB_ENTRIES;
    localparam int IDX_W = ftlb_pkg::IDX_W;
    localparam int CNT_W = ftlb_pkg::CNT_W;
    localparam int CMP_W = ftlb_pkg::CMP_W;

    ftlb_pkg::entry_t                  slot_reg [N];
    logic [ftlb_pkg::CFG_W-1:0]        cfg_reg;
    logic [CNT_W-1:0]                  occ_reg;
    logic [CNT_W-1:0]                  occ_next;
    logic [CNT_W-1:0]                  rd_ptr_reg;
    logic [CNT_W-1:0]                  wr_ptr_reg;
    ftlb_pkg::func_t                   func_reg;
    logic [ftlb_pkg::PID_W-1:0]        pid_reg;
    logic [ftlb_pkg::PAGE_W-1:0]       page_reg;
    logic [ftlb_pkg::FRAME_W-1:0]      frame_reg;
    logic [N-1:0]                      match_reg;
    logic                              res_hit_reg;
    logic [ftlb_pkg::FRAME_W-1:0]      res_frame_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              out_hit_reg;
    logic [ftlb_pkg::FRAME_W-1:0]      out_frame_reg;

    logic [CMP_W-1:0]                  cfg_ext;
    logic [CMP_W-1:0]                  cap_full;
    logic [CNT_W-1:0]                  cap;
    logic                              cap_zero;
    logic                              evict;
    logic [CNT_W-1:0]                  ins_ptr;
    logic                              do_insert;
    logic [N-1:0]                      match;
    logic [N-1:0]                      oldest;
    logic [ftlb_pkg::FRAME_W-1:0]      sel_frame;
    ftlb_pkg::entry_t                  rd_entry;
    logic                              scan_end;
    logic                              keep;

    // effective capacity, clamped to the array size
    assign cfg_ext  = CMP_W'(cfg_reg);
    assign cap_full = (cfg_ext > CMP_W'(N)) ? CMP_W'(N) : cfg_ext;
    assign cap      = CNT_W'(cap_full);
    assign cap_zero = (cap == '0);

    assign evict     = (occ_reg >= cap);
    assign ins_ptr   = evict ? (occ_reg - CNT_W'(1)) : occ_reg;
    assign do_insert = cmd.exec && (func_reg == ftlb_pkg::FUNC_INSERT) && !cap_zero;

    assign rd_entry = slot_reg[rd_ptr_reg[IDX_W-1:0]];
    assign scan_end = (rd_ptr_reg == occ_reg);
    assign keep     = (rd_entry.pid != pid_reg);

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = !cap_zero && (CNT_W'(i) < occ_reg)
                       && (slot_reg[i].pid == pid_reg) && (slot_reg[i].page == page_reg);
        end
    end

    // isolate lowest set bit, then and-or select
    assign oldest = match_reg & (~match_reg + N'(1));

    always_comb
    begin
        sel_frame = '0;
        for (int i = 0; i < N; i++)
        begin
            sel_frame = sel_frame | (oldest[i] ? slot_reg[i].frame : '0);
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.exec)
        begin
            case (func_reg)
                ftlb_pkg::FUNC_INSERT:
                begin
                    if (!cap_zero && !evict)
                    begin
                        occ_next = occ_reg + CNT_W'(1);
                    end
                end
                ftlb_pkg::FUNC_FLUSH_ALL:
                begin
                    occ_next = '0;
                end
                default:
                begin
                    occ_next = occ_reg;
                end
            endcase
        end
        if (cmd.scan_step && scan_end)
        begin
            occ_next = wr_ptr_reg;
        end
    end

    assign out_valid_next = cmd.load_out ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= ftlb_pkg::CFG_RESET;
            occ_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cmd.exec)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
            end
            else if (cmd.scan_step && !scan_end)
            begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
                if (keep)
                begin
                    wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
                end
            end
        end
    end

    // entry storage and transaction payload
    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            if (evict)
            begin
                // shift down everything but the slot that takes the new entry
                for (int i = 0; i < N - 1; i++)
                begin
                    if (CNT_W'(i) != ins_ptr)
                    begin
                        slot_reg[i] <= slot_reg[i + 1];
                    end
                end
            end
            slot_reg[ins_ptr[IDX_W-1:0]] <= '{pid: pid_reg, page: page_reg, frame: frame_reg};
        end
        else if (cmd.scan_step && !scan_end && keep)
        begin
            slot_reg[wr_ptr_reg[IDX_W-1:0]] <= rd_entry;
        end

        if (cmd.latch)
        begin
            func_reg      <= in_func;
            pid_reg       <= in_pid;
            page_reg      <= in_page;
            frame_reg     <= in_frame;
            res_hit_reg   <= 1'b0;
            res_frame_reg <= '0;
        end
        else if (cmd.pick)
        begin
            res_hit_reg   <= |match_reg;
            res_frame_reg <= sel_frame;
        end

        if (cmd.exec)
        begin
            match_reg <= match;
        end

        if (cmd.load_out)
        begin
            out_hit_reg   <= res_hit_reg;
            out_frame_reg <= res_frame_reg;
        end
    end

    assign status.func     = func_reg;
    assign status.scan_end = scan_end;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_frame = out_frame_reg;

endmodule

// File: hw/rtl/ftlb_ctrl.sv
module ftlb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ftlb_pkg::status_t status,
    output ftlb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PICK,
        ST_SCAN,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (status.func)
                    ftlb_pkg::FUNC_LOOKUP:    state_next = ST_PICK;
                    ftlb_pkg::FUNC_FLUSH_PID: state_next = ST_SCAN;
                    default:                  state_next = ST_RESP;
                endcase
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_RESP;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                cmd.load_out = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = ready_reg;

endmodule

// File: hw/rtl/fifo_tlb_with_pid_flush.sv
// Fully associative translation buffer, 16 entries of (pid, page, frame), kept
// in age order with first-in first-out replacement. Each slave transaction
// carries one operation in s_tuser: lookup, insert, flush all, or flush the
// entries of one pid; each produces exactly one master transaction with hit in
// m_tuser and frame in m_tdata (frame is zero on a miss and for non-lookups).
// A lookup returns the oldest matching entry. An insert does not check for
// duplicates; when the buffer holds at least entries_in_use entries it evicts
// the oldest, then appends the new one. entries_in_use (cfg_wdata, reset 16,
// clamped to 16) of zero makes lookups miss and inserts do nothing; write it
// only while no operation is in flight. Operations run one at a time: a lookup
// compares all entries in parallel into a match register, then picks the oldest
// match into a result register and moves it into the output register; insert
// and flush all load the output register after their execute step; flush by
// pid first compacts the entries, reading one entry per cycle through a single
// read port and copying the surviving entries down. The next operation is
// taken once the result is in the output register. The result sits in an
// output register, so a stalled master side only holds up the next result,
// not the acceptance of the next operation.
module fifo_tlb_with_pid_flush (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration: entries_in_use
    input  logic                                cfg_we,
    input  logic [ftlb_pkg::CFG_W-1:0]          cfg_wdata,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ftlb_pkg::S_TDATA_W-1:0]      s_tdata,   // pid, page, frame_in
    input  logic [ftlb_pkg::FUNC_W-1:0]         s_tuser,   // func
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ftlb_pkg::M_TDATA_W-1:0]      m_tdata,   // frame_out, zero pad
    output logic                                m_tuser    // hit
);

    localparam int PID_W   = ftlb_pkg::PID_W;
    localparam int PAGE_W  = ftlb_pkg::PAGE_W;
    localparam int FRAME_W = ftlb_pkg::FRAME_W;

    ftlb_pkg::cmd_t          cmd;
    ftlb_pkg::status_t       status;
    logic [FRAME_W-1:0]      out_frame;

    // controller: sequences one transaction at a time
    ftlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: entry array, compare, compaction and output register
    ftlb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_func   (ftlb_pkg::func_t'(s_tuser)),
        .in_pid    (s_tdata[PID_W-1:0]),
        .in_page   (s_tdata[PID_W+PAGE_W-1:PID_W]),
        .in_frame  (s_tdata[PID_W+PAGE_W+FRAME_W-1:PID_W+PAGE_W]),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_hit   (m_tuser),
        .out_frame (out_frame)
    );

    // frame in the low bits, zero fill to a whole byte
    assign m_tdata = ftlb_pkg::M_TDATA_W'(out_frame);

endmodule

// File: hw/rtl/ftlb_checker.sv
`include "fifo_tlb_with_pid_flush_macros.svh"

module ftlb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ftlb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // one operation in flight: no acceptance right after one
    `FTLB_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second transaction accepted while busy")

    // a miss or a non-lookup reports frame zero
    `FTLB_ASSERT_NOW(a_miss_zero_frame, m_tvalid && !m_tuser, m_tdata == '0, "nonzero frame without hit")

    // stalled result holds
    `FTLB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

endmodule

bind fifo_tlb_with_pid_flush ftlb_checker u_ftlb_checker (.*);
